// ----- rtl/core/xcpd_pkg.sv -----
// Package for the XOR-checked packet deframer: channel payload structs,
// parser phase encoding, status and item-kind codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xcpd_pkg;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] payload_byte;
      logic [7:0] packet_id;
      logic [7:0] frame_length;
      logic [7:0] checksum;
      logic [2:0] status;
   } rsp_type;

   // One result candidate from the parser for the byte on the request port.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } res_type;

   typedef enum logic [2:0] {
      PH_LEN     = 3'd0,
      PH_ID      = 3'd1,
      PH_PAYLOAD = 3'd2,
      PH_CSUM    = 3'd3,
      PH_END     = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_BAD_END    = 3'd1;
   localparam logic [2:0] STATUS_BAD_CSUM   = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED  = 3'd3;
   localparam logic [2:0] STATUS_ZERO_LEN   = 3'd4;

endpackage

`default_nettype wire

// ----- rtl/core/xcpd_parse.sv -----
// Frame parser state and per-byte result logic.
// Depends on xcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpd_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire xcpd_pkg::req_type req_data,
   input  wire logic [7:0]       end_marker,
   output xcpd_pkg::res_type     res
);

   xcpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] left_ff, left_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] csum_ff, csum_in;

   logic       emit_status;
   logic       emit_payload;
   logic [2:0] code;
   logic [7:0] b;
   logic       last;

   assign b    = req_data.rx_byte;
   assign last = req_data.buffer_end;

   // Next state
   always_comb begin
      phase_in     = phase_ff;
      length_in    = length_ff;
      id_in        = id_ff;
      left_in      = left_ff;
      xor_in       = xor_ff;
      csum_in      = csum_ff;
      emit_status  = 1'b0;
      emit_payload = 1'b0;
      code         = xcpd_pkg::STATUS_OK;
      unique case (phase_ff)
         xcpd_pkg::PH_LEN: begin
            length_in = b;
            id_in     = 8'd0;
            csum_in   = 8'd0;
            xor_in    = b;
            left_in   = b - 8'd1;
            if (b == 8'd0) begin
               emit_status = 1'b1;
               code        = xcpd_pkg::STATUS_ZERO_LEN;
               phase_in    = xcpd_pkg::PH_DONE;
            end else begin
               phase_in = xcpd_pkg::PH_ID;
            end
         end
         xcpd_pkg::PH_ID: begin
            id_in    = b;
            xor_in   = xor_ff ^ b;
            phase_in = (left_ff == 8'd0) ? xcpd_pkg::PH_CSUM : xcpd_pkg::PH_PAYLOAD;
         end
         xcpd_pkg::PH_PAYLOAD: begin
            xor_in       = xor_ff ^ b;
            left_in      = left_ff - 8'd1;
            emit_payload = !last;
            if (left_in == 8'd0) begin
               phase_in = xcpd_pkg::PH_CSUM;
            end
         end
         xcpd_pkg::PH_CSUM: begin
            csum_in  = b;
            phase_in = xcpd_pkg::PH_END;
         end
         xcpd_pkg::PH_END: begin
            emit_status = 1'b1;
            if (b != end_marker) begin
               code = xcpd_pkg::STATUS_BAD_END;
            end else if (csum_ff != xor_ff) begin
               code = xcpd_pkg::STATUS_BAD_CSUM;
            end else begin
               code = xcpd_pkg::STATUS_OK;
            end
            phase_in = xcpd_pkg::PH_DONE;
         end
         default: begin
            phase_in = xcpd_pkg::PH_DONE;
         end
      endcase
      // Buffer end: report truncation of an open frame, rearm for the next buffer.
      if (last) begin
         if (!emit_status && !emit_payload && phase_in != xcpd_pkg::PH_DONE) begin
            emit_status = 1'b1;
            code        = xcpd_pkg::STATUS_TRUNCATED;
         end
         phase_in = xcpd_pkg::PH_LEN;
      end
   end

   // Result item
   always_comb begin
      res.valid = emit_status || emit_payload;
      res.data  = '0;
      if (emit_status) begin
         res.data.item_kind    = xcpd_pkg::KIND_STATUS;
         res.data.packet_id    = id_in;
         res.data.frame_length = length_in;
         res.data.checksum     = csum_in;
         res.data.status       = code;
      end else begin
         res.data.item_kind    = xcpd_pkg::KIND_PAYLOAD;
         res.data.payload_byte = b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= xcpd_pkg::PH_LEN;
         length_ff <= 8'd0;
         id_ff     <= 8'd0;
         left_ff   <= 8'd0;
         xor_ff    <= 8'd0;
         csum_ff   <= 8'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         id_ff     <= id_in;
         left_ff   <= left_in;
         xor_ff    <= xor_in;
         csum_ff   <= csum_in;
      end
   end

   a_last_rearms: assert property (@(posedge clock) disable iff (reset)
      accept && last |=> phase_ff == xcpd_pkg::PH_LEN)
      else $error("buffer end did not rearm the parser");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == xcpd_pkg::PH_DONE |-> !res.valid)
      else $error("result produced after frame closed");

   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == xcpd_pkg::PH_LEN && b == 8'd0 && !last
      |=> phase_ff == xcpd_pkg::PH_DONE)
      else $error("zero length did not close the frame");

endmodule

`default_nettype wire

// ----- rtl/core/xcpd_out_reg.sv -----
// Result register with a skid entry, so the request side keeps moving while
// a result waits. Depends on xcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xcpd_out_reg (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire xcpd_pkg::rsp_type push_data,
   output logic               space,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output xcpd_pkg::rsp_type  rsp_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   xcpd_pkg::rsp_type main_data_ff, main_data_in;
   xcpd_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              pop;

   assign pop       = main_valid_ff && rsp_ready;
   assign space     = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a main entry");

   a_push_stalled: assert property (@(posedge clock) disable iff (reset)
      push && main_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("stalled push not caught by skid entry");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && !skid_valid_ff && !push |=> !main_valid_ff)
      else $error("result register did not drain");

endmodule

`default_nettype wire

// ----- rtl/core/xor_checked_packet_deframer.sv -----
// Top level of the XOR-checked packet deframer: parser plus result register.
// A result is registered in the result register before it appears on rsp.
// Throughput: one byte per cycle while req_ready is high; the parser state updates in a single pass.
// req_ready drops only while both result entries are full (rsp stalled).
// Reset (synchronous, active high) rearms for a length byte, empties the
// result register and sets the end marker to zero. Depends on xcpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_packet_deframer (
   input  wire logic         clock,
   input  wire logic         reset,
   // byte input
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire xcpd_pkg::req_type req_data,
   // result output
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output xcpd_pkg::rsp_type rsp_data,
   // end marker register
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_data
);

   logic              accept;
   logic              space;
   logic [7:0]        end_marker_ff;
   xcpd_pkg::res_type res;

   // Always take a register write; the user must write only while the block is idle (not enforced here).
   assign csr_ready = 1'b1;

   // Hold off new bytes only when no result slot is free.
   assign req_ready = space;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_marker_ff <= 8'd0;
      end else if (csr_valid && csr_ready) begin
         end_marker_ff <= csr_data;
      end
   end

   // Advance the frame state once per byte transfer.
   xcpd_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .end_marker (end_marker_ff),
      .res        (res)
   );

   // Queue the result of the transfer, if any, toward rsp.
   xcpd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && res.valid),
      .push_data (res.data),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
